### rtl/idrm_pkg.sv
// Shared types and constants for the rounding integer divider.
package idrm_pkg;

  localparam int unsigned Width = 32;

  typedef enum logic [1:0] {
    ModeFloor = 2'd0,
    ModeCeil  = 2'd1,
    ModeTrunc = 2'd2,
    ModeRound = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusDivZero  = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                    op;
    logic signed [Width-1:0]  dividend;
    logic signed [Width-1:0]  divisor;
  } in_item_t;

  typedef struct packed {
    logic signed [Width-1:0]  quotient;
    logic signed [Width-1:0]  remainder;
    status_e                  status;
  } out_item_t;

endpackage

### rtl/integer_divide_rounding_modes.sv
// Pipelined signed divider with floor, ceiling, truncate and round-half-even modes.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries the mode, dividend and
// divisor; output channel (out_valid_o / out_stall_i / out_data_o) carries quotient,
// remainder (dividend - quotient * divisor) and status. A transfer happens on a rising
// edge with valid high and stall low.
//
// Throughput: one item per cycle while the output is not stalled. The pipeline is
// Width + 4 registers deep: the restoring divide chain, one quotient bit per stage,
// plus an operand stage, a rounding decision stage, a correction stage and the output
// register.
//
// A zero divisor gives status 1 with zero quotient and remainder. The most negative
// dividend over -1 gives status 2 with the wrapped quotient and a zero remainder.
//
// Reset clears all valid bits; the pipeline comes up empty. While the output holds a
// result that the receiver stalls, the whole pipeline freezes and in_stall_o is high;
// nothing is dropped or repeated.
module integer_divide_rounding_modes (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  idrm_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output idrm_pkg::out_item_t   out_data_o
);

  localparam int unsigned W = idrm_pkg::Width;

  typedef struct packed {
    logic [W-1:0]     rem;
    logic [W-1:0]     numq;   // dividend bits shift out, quotient bits shift in
    logic [W-1:0]     dm;
    idrm_pkg::mode_e  op;
    logic             nneg;
    logic             neg;
    logic             dz;
  } div_stage_t;

  typedef struct packed {
    logic [W-1:0]     qm;
    logic [W-1:0]     rm;
    logic [W-1:0]     dm;
    logic             inc;
    logic             nneg;
    logic             neg;
    logic             dz;
  } rnd_stage_t;

  typedef struct packed {
    logic [W-1:0]     qm;
    logic [W-1:0]     rmag;
    logic             nneg;
    logic             neg;
    logic             dz;
    logic             ovf;
  } fix_stage_t;

  logic adv;

  logic [W:0]       div_v_q;
  div_stage_t       div_q [W+1];
  div_stage_t       div_d [W+1];

  logic             rnd_v_q;
  rnd_stage_t       rnd_q, rnd_d;
  logic             fix_v_q;
  fix_stage_t       fix_q, fix_d;
  logic             out_valid_q;
  idrm_pkg::out_item_t out_q, out_d;

  // whole pipeline moves unless the output holds a stalled result
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // operand stage: magnitudes and signs
  always_comb begin
    logic [W-1:0] n_u;
    logic [W-1:0] d_u;
    n_u = in_data_i.dividend;
    d_u = in_data_i.divisor;
    div_d[0].rem  = '0;
    div_d[0].numq = n_u[W-1] ? (~n_u + 1'b1) : n_u;
    div_d[0].dm   = d_u[W-1] ? (~d_u + 1'b1) : d_u;
    div_d[0].op   = in_data_i.op;
    div_d[0].nneg = n_u[W-1];
    div_d[0].neg  = n_u[W-1] ^ d_u[W-1];
    div_d[0].dz   = (d_u == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else if (adv) begin
      div_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_d[0];
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W-1:0] trial;
    logic [W:0]   diff;
    logic         ge;

    // rem < dm <= 2^(W-1), so its top bit is zero and the shift loses nothing
    assign trial = {div_q[k].rem[W-2:0], div_q[k].numq[W-1]};
    assign diff  = {1'b0, trial} - {1'b0, div_q[k].dm};
    assign ge    = !diff[W];

    always_comb begin
      div_d[k+1]      = div_q[k];
      div_d[k+1].rem  = ge ? diff[W-1:0] : trial;
      div_d[k+1].numq = {div_q[k].numq[W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        div_v_q[k+1] <= div_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k+1] <= div_d[k+1];
      end
    end
  end

  // rounding decision
  always_comb begin
    logic [W:0] twice;
    logic [W:0] dmx;
    logic       nz;
    twice = {div_q[W].rem, 1'b0};
    dmx   = {1'b0, div_q[W].dm};
    nz    = (div_q[W].rem != '0);
    rnd_d.qm   = div_q[W].numq;
    rnd_d.rm   = div_q[W].rem;
    rnd_d.dm   = div_q[W].dm;
    rnd_d.nneg = div_q[W].nneg;
    rnd_d.neg  = div_q[W].neg;
    rnd_d.dz   = div_q[W].dz;
    unique case (div_q[W].op)
      idrm_pkg::ModeFloor: rnd_d.inc = div_q[W].neg && nz;
      idrm_pkg::ModeCeil:  rnd_d.inc = !div_q[W].neg && nz;
      idrm_pkg::ModeTrunc: rnd_d.inc = 1'b0;
      idrm_pkg::ModeRound: rnd_d.inc = (twice > dmx) || ((twice == dmx) && div_q[W].numq[0]);
      default:             rnd_d.inc = 1'b0;
    endcase
  end

  // quotient bump; remainder magnitude follows as rm - dm when bumped
  always_comb begin
    fix_d.qm   = rnd_q.qm + {{(W-1){1'b0}}, rnd_q.inc};
    fix_d.rmag = rnd_q.inc ? (rnd_q.rm - rnd_q.dm) : rnd_q.rm;
    fix_d.nneg = rnd_q.nneg;
    fix_d.neg  = rnd_q.neg;
    fix_d.dz   = rnd_q.dz;
    // qm never exceeds 2^(W-1), so the top bit alone marks a positive overflow
    fix_d.ovf  = !rnd_q.neg && fix_d.qm[W-1];
  end

  // sign restore and status
  always_comb begin
    logic [W-1:0] q_s;
    logic [W-1:0] r_s;
    q_s = fix_q.neg  ? (~fix_q.qm + 1'b1)   : fix_q.qm;
    r_s = fix_q.nneg ? (~fix_q.rmag + 1'b1) : fix_q.rmag;
    priority if (fix_q.dz) begin
      out_d.quotient  = '0;
      out_d.remainder = '0;
      out_d.status    = idrm_pkg::StatusDivZero;
    end else if (fix_q.ovf) begin
      out_d.quotient  = q_s;
      out_d.remainder = r_s;
      out_d.status    = idrm_pkg::StatusOverflow;
    end else begin
      out_d.quotient  = q_s;
      out_d.remainder = r_s;
      out_d.status    = idrm_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_v_q     <= 1'b0;
      fix_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      rnd_v_q     <= div_v_q[W];
      fix_v_q     <= rnd_v_q;
      out_valid_q <= fix_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rnd_q <= rnd_d;
      fix_q <= fix_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // final partial remainder must be below the divisor magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_v_q[W] && !div_q[W].dz) |-> (div_q[W].rem < div_q[W].dm))
    else $error("partial remainder not reduced below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == idrm_pkg::StatusDivZero) |->
      (out_q.quotient == '0 && out_q.remainder == '0))
    else $error("divide by zero result not cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == idrm_pkg::StatusOverflow) |->
      (out_q.quotient == {1'b1, {(W-1){1'b0}}} && out_q.remainder == '0))
    else $error("overflow result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && fix_v_q) |=> out_valid_q)
    else $error("item lost between correction stage and output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rnd_v_q && !rnd_q.dz && rnd_q.inc) |-> (rnd_q.rm != '0))
    else $error("quotient bumped with exact division");

endmodule

### tb/integer_divide_rounding_modes_tb.sv
// Self-checking testbench for the rounding signed divider: directed corners plus random traffic.
module integer_divide_rounding_modes_tb;

  localparam int unsigned Width = idrm_pkg::Width;
  localparam logic [Width-1:0] MinVal = {1'b1, {(Width-1){1'b0}}};
  localparam logic [Width-1:0] MaxVal = ~MinVal;
  localparam int unsigned WatchdogLimit = 2000;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  idrm_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  idrm_pkg::out_item_t out_data_o;

  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  idrm_pkg::out_item_t expected_results[$];
  idrm_pkg::out_item_t oldest_result;

  integer_divide_rounding_modes u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Predicted result: divide magnitudes, bump the magnitude per mode, restore the sign.
  function automatic idrm_pkg::out_item_t divide_rounded(idrm_pkg::in_item_t item);
    idrm_pkg::out_item_t res;
    logic [Width-1:0] n, d, nm, dm, qm, rm, q;
    logic [Width:0] qm_ext, half, limit;
    logic neg, bump;
    res = '0;
    n = item.dividend;
    d = item.divisor;
    if (d == '0) begin
      res.status = idrm_pkg::StatusDivZero;
      return res;
    end
    nm = n[Width-1] ? (~n + 1'b1) : n;
    dm = d[Width-1] ? (~d + 1'b1) : d;
    neg = n[Width-1] ^ d[Width-1];
    qm = nm / dm;
    rm = nm % dm;
    case (item.op)
      idrm_pkg::ModeFloor: bump = neg && (rm != '0);
      idrm_pkg::ModeCeil:  bump = !neg && (rm != '0);
      idrm_pkg::ModeTrunc: bump = 1'b0;
      default:             bump = (rm > dm - rm) || ((rm == dm - rm) && qm[0]);
    endcase
    qm_ext = {1'b0, qm} + {{Width{1'b0}}, bump};
    half = '0;
    half[Width-1] = 1'b1;
    limit = neg ? half : half - 1'b1;
    q = neg ? (~qm_ext[Width-1:0] + 1'b1) : qm_ext[Width-1:0];
    res.quotient = q;
    res.remainder = n - q * d;
    res.status = (qm_ext > limit) ? idrm_pkg::StatusOverflow : idrm_pkg::StatusOk;
    return res;
  endfunction

  function automatic idrm_pkg::in_item_t make_item(idrm_pkg::mode_e md,
                                                   logic [Width-1:0] n,
                                                   logic [Width-1:0] d);
    idrm_pkg::in_item_t item;
    item.op = md;
    item.dividend = n;
    item.divisor = d;
    return item;
  endfunction

  function automatic logic [Width-1:0] rand_operand();
    logic [Width-1:0] v;
    case ($urandom_range(5))
      0: v = Width'($urandom_range(40)) - Width'(20);
      1: begin
        case ($urandom_range(4))
          0: v = MinVal;
          1: v = MaxVal;
          2: v = '1;
          3: v = Width'(1);
          default: v = '0;
        endcase
      end
      2: begin
        v = Width'($urandom()) >> $urandom_range(Width - 1);
        if ($urandom_range(1)) v = -v;
      end
      3: v = Width'($urandom_range(1000));
      default: v = Width'($urandom());
    endcase
    return v;
  endfunction

  // Offer one item, hold it until the transfer, then queue its predicted result.
  task automatic send_item(input idrm_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(divide_rounded(item));
  endtask

  task automatic test_divide_by_zero();
    idrm_pkg::mode_e md;
    md = idrm_pkg::ModeFloor;
    repeat (4) begin
      send_item(make_item(md, rand_operand(), '0));
      md = md.next();
    end
  endtask

  task automatic test_overflow();
    idrm_pkg::mode_e md;
    md = idrm_pkg::ModeFloor;
    repeat (4) begin
      send_item(make_item(md, MinVal, '1));
      md = md.next();
    end
  endtask

  // 7/2 ties on an odd truncated quotient, -5/2 on an even one
  task automatic test_rounding_ties();
    idrm_pkg::mode_e md;
    md = idrm_pkg::ModeFloor;
    repeat (4) begin
      send_item(make_item(md, Width'(7), Width'(2)));
      send_item(make_item(md, -Width'(5), Width'(2)));
      md = md.next();
    end
  endtask

  task automatic test_operand_extremes();
    send_item(make_item(idrm_pkg::ModeFloor, MaxVal, MinVal));
    send_item(make_item(idrm_pkg::ModeCeil, MinVal, MinVal));
    send_item(make_item(idrm_pkg::ModeTrunc, MinVal, Width'(1)));
    send_item(make_item(idrm_pkg::ModeRound, MaxVal, '1));
    send_item(make_item(idrm_pkg::ModeCeil, '0, -Width'(3)));
    send_item(make_item(idrm_pkg::ModeRound, MaxVal, MaxVal));
  endtask

  task automatic test_random(input int unsigned count, input int unsigned tx_pct,
                             input int unsigned rx_pct);
    idrm_pkg::in_item_t item;
    logic [Width-1:0] d;
    send_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) begin
      item.op = idrm_pkg::mode_e'($urandom_range(3));
      case ($urandom_range(19))
        0, 1, 2: begin
          // exact half: dividend = k * d + d / 2 with an even divisor
          d = Width'(2 * $urandom_range(1, 500));
          item.dividend = Width'($urandom_range(2000)) * d + (d >> 1);
          item.divisor = d;
          if ($urandom_range(1)) item.dividend = -item.dividend;
          if ($urandom_range(1)) item.divisor = -item.divisor;
        end
        3: begin
          item.dividend = rand_operand();
          item.divisor = '0;
        end
        4: begin
          item.dividend = MinVal;
          item.divisor = $urandom_range(1) ? '1 : Width'(1);
        end
        default: begin
          item.dividend = rand_operand();
          item.divisor = rand_operand();
        end
      endcase
      send_item(item);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0d %0d %0d", $time,
                 out_data_o.quotient, out_data_o.remainder, out_data_o.status);
        mismatch_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_data_o.quotient !== oldest_result.quotient) begin
          $display("%0t: quotient mismatch, expected %0d actual %0d", $time,
                   oldest_result.quotient, out_data_o.quotient);
          mismatch_count++;
        end
        if (out_data_o.remainder !== oldest_result.remainder) begin
          $display("%0t: remainder mismatch, expected %0d actual %0d", $time,
                   oldest_result.remainder, out_data_o.remainder);
          mismatch_count++;
        end
        if (out_data_o.status !== oldest_result.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time,
                   oldest_result.status, out_data_o.status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 21;
    rx_stall_pct = 45;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_divide_by_zero();
    test_overflow();
    test_rounding_ties();
    test_operand_extremes();
    test_random(700, 21, 45);
    test_random(700, 45, 21);
    test_random(600, 0, 0);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (Width + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
